// File: hdl/mips_subset_single_cycle_core_assert.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define MSSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSSC_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MSSC_ASSERT(label, clk, rst, prop, msg)
`define MSSC_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: hdl/mssc_pkg.sv
package mssc_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned REG_W         = 5;
   localparam int unsigned REG_COUNT     = 32;
   localparam int unsigned REQ_W         = 2;
   localparam int unsigned WIDX_W        = 14;
   localparam int unsigned START_W       = 16;
   localparam int unsigned MEM_BYTES_DEF = 65536;
   localparam logic [START_W-1:0] START_RESET = 16'h4000;

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_SLTIU = 6'h0B;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2B;

   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD = 2'd0,
      REQ_EXEC = 2'd1,
      REQ_READ = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_SLT,
      ALU_SLTU,
      ALU_AND,
      ALU_OR,
      ALU_LUI
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SIMPLE,
      ST_EXEC,
      ST_MEM
   } state_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [WIDX_W-1:0] word_index;
      logic [DATA_W-1:0] load_word;
      logic [REG_W-1:0]  register_select;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] pc_value;
      logic [DATA_W-1:0] executed_instruction;
      logic [DATA_W-1:0] alu_result;
      logic              halted;
      logic [REG_W-1:0]  written_register;
      logic [DATA_W-1:0] written_value;
      logic [DATA_W-1:0] register_value;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [REG_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic              ok;
      logic              wr;
      logic              is_lw;
      logic              is_sw;
      logic              is_beq;
      logic              is_j;
      logic [REG_W-1:0]  dest;
      logic [DATA_W-1:0] imm;
      logic [DATA_W-1:0] alu;
   } dec_type;

endpackage

// File: hdl/mssc_if.sv
interface mssc_req_if import mssc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [WIDX_W-1:0] word_index;
   logic [DATA_W-1:0] load_word;
   logic [REG_W-1:0]  register_select;

   modport source (
      output valid, req_type, word_index, load_word, register_select,
      input  ready
   );
   modport sink (
      input  valid, req_type, word_index, load_word, register_select,
      output ready
   );
endinterface

interface mssc_rsp_if import mssc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pc_value;
   logic [DATA_W-1:0] executed_instruction;
   logic [DATA_W-1:0] alu_result;
   logic              halted;
   logic [REG_W-1:0]  written_register;
   logic [DATA_W-1:0] written_value;
   logic [DATA_W-1:0] register_value;

   modport source (
      output valid, pc_value, executed_instruction, alu_result, halted,
             written_register, written_value, register_value,
      input  ready
   );
   modport sink (
      input  valid, pc_value, executed_instruction, alu_result, halted,
             written_register, written_value, register_value,
      output ready
   );
endinterface

interface mssc_csr_if import mssc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [START_W-1:0] start_address;

   modport source (
      output valid, start_address,
      input  ready
   );
   modport sink (
      input  valid, start_address,
      output ready
   );
endinterface

// File: hdl/mssc_mem.sv
module mssc_mem import mssc_pkg::*; #(
   parameter int unsigned DEPTH = MEM_BYTES_DEF / 4,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_raw_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff   <= mem_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // same-edge write to the address being read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_raw_ff;
endmodule

// File: hdl/mssc_rf.sv
module mssc_rf import mssc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_a_en,
   input  logic [REG_W-1:0]  rd_a_addr,
   output logic [DATA_W-1:0] rd_a_data,
   input  logic              rd_b_en,
   input  logic [REG_W-1:0]  rd_b_addr,
   output logic [DATA_W-1:0] rd_b_data,
   input  rf_wr_type         wr
);
   logic [DATA_W-1:0]    rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;
   logic [DATA_W-1:0]    rd_a_ff;
   logic [DATA_W-1:0]    rd_b_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rf_ff[wr.addr] <= wr.data;
      end
   end

   // unwritten entries read as zero; same-edge write forwarded
   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         if (wr.en && (wr.addr == rd_a_addr)) begin
            rd_a_ff <= wr.data;
         end else if (vld_ff[rd_a_addr]) begin
            rd_a_ff <= rf_ff[rd_a_addr];
         end else begin
            rd_a_ff <= '0;
         end
      end
      if (rd_b_en) begin
         if (wr.en && (wr.addr == rd_b_addr)) begin
            rd_b_ff <= wr.data;
         end else if (vld_ff[rd_b_addr]) begin
            rd_b_ff <= rf_ff[rd_b_addr];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;
endmodule

// File: hdl/mssc_alu.sv
module mssc_alu import mssc_pkg::*; (
   input  logic [DATA_W-1:0] instr,
   input  logic [DATA_W-1:0] rs_value,
   input  logic [DATA_W-1:0] rt_value,
   output dec_type           dec
);
   alu_op_type        cmd;
   logic [DATA_W-1:0] b;
   logic [DATA_W-1:0] imm;
   logic [DATA_W-1:0] res;
   logic              use_rd;

   always_comb begin
      imm    = {{16{instr[15]}}, instr[15:0]};
      b      = imm;
      cmd    = ALU_ADD;
      use_rd = 1'b0;
      dec    = '0;
      dec.ok = 1'b1;
      unique case (instr[31:26])
         OP_RTYPE: begin
            b      = rt_value;
            dec.wr = 1'b1;
            use_rd = 1'b1;
            unique case (instr[5:0])
               FN_ADD:  cmd = ALU_ADD;
               FN_SUB:  cmd = ALU_SUB;
               FN_SLT:  cmd = ALU_SLT;
               FN_SLTU: cmd = ALU_SLTU;
               FN_AND:  cmd = ALU_AND;
               FN_OR:   cmd = ALU_OR;
               default: dec.ok = 1'b0;
            endcase
         end
         OP_J: begin
            b        = '0;
            dec.is_j = 1'b1;
         end
         OP_BEQ: begin
            b          = rt_value;
            cmd        = ALU_SUB;
            dec.is_beq = 1'b1;
         end
         OP_ADDI:  dec.wr = 1'b1;
         OP_SLTI: begin
            cmd    = ALU_SLT;
            dec.wr = 1'b1;
         end
         OP_SLTIU: begin
            cmd    = ALU_SLTU;
            dec.wr = 1'b1;
         end
         OP_LUI: begin
            cmd    = ALU_LUI;
            dec.wr = 1'b1;
         end
         OP_LW: begin
            dec.wr    = 1'b1;
            dec.is_lw = 1'b1;
         end
         OP_SW:   dec.is_sw = 1'b1;
         default: dec.ok = 1'b0;
      endcase

      unique case (cmd)
         ALU_ADD:  res = rs_value + b;
         ALU_SUB:  res = rs_value - b;
         ALU_SLT:  res = {31'b0, $signed(rs_value) < $signed(b)};
         ALU_SLTU: res = {31'b0, rs_value < b};
         ALU_AND:  res = rs_value & b;
         ALU_OR:   res = rs_value | b;
         ALU_LUI:  res = {b[15:0], 16'b0};
         default:  res = '0;
      endcase

      dec.imm = imm;
      dec.alu = dec.ok ? res : '0;
      if (dec.ok && dec.wr) begin
         dec.dest = use_rd ? instr[15:11] : instr[20:16];
      end
   end
endmodule

// File: hdl/mips_subset_single_cycle_core.sv
// channel   dir  handshake      payload
// req_chan  in   valid/ready    req_type, word_index, load_word, register_select
// rsp_chan  out  valid/ready    pc, instruction, alu, halted, write, register value
// csr_chan  in   valid/ready=1  start_address (also loads the PC)
//
// Execute steps, ending after the fetch read when halted or on a fetch fault:
// fetch read, register-file read, then ALU and, for lw, a second read of the word memory.
// Load and register-read requests finish in the ST_SIMPLE state.
// Reset: PC to 0x4000, halt cleared, register file reads zero.
// A result waits in the output register; the next request is accepted
// meanwhile and holds in its last step until the output register frees.
`include "mips_subset_single_cycle_core_assert.svh"
module mips_subset_single_cycle_core import mssc_pkg::*; #(
   parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   mssc_req_if.sink   req_chan,
   mssc_rsp_if.source rsp_chan,
   mssc_csr_if.sink   csr_chan
);
   localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
   localparam int unsigned AW = $clog2(MEM_WORDS);

   state_type         state_ff, state_in, entry_state;
   logic [DATA_W-1:0] pc_ff, pc_in, pc4, npc;
   logic              halt_ff, halt_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;
   req_item_type      req_ff;
   logic [DATA_W-1:0] instr_ff;
   logic [DATA_W-1:0] alu_ff;
   logic [REG_W-1:0]  dest_ff;

   logic              accept, csr_wr, finish, fin_state, slot_free;
   logic              pc_bad, data_bad, exec_fault, lw_go, widx_ok;

   logic              mem_rd_en, mem_wr_en;
   logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
   logic [DATA_W-1:0] mem_rd_data, mem_wr_data;

   logic              rf_a_en, rf_b_en;
   logic [REG_W-1:0]  rf_a_addr;
   logic [DATA_W-1:0] rf_a_data, rf_b_data;
   rf_wr_type         rf_wr;
   dec_type           dec;

   mssc_mem #(.DEPTH(MEM_WORDS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   mssc_rf u_rf (
      .clock     (clock),
      .reset     (reset),
      .rd_a_en   (rf_a_en),
      .rd_a_addr (rf_a_addr),
      .rd_a_data (rf_a_data),
      .rd_b_en   (rf_b_en),
      .rd_b_addr (mem_rd_data[20:16]),
      .rd_b_data (rf_b_data),
      .wr        (rf_wr)
   );

   mssc_alu u_alu (
      .instr    (instr_ff),
      .rs_value (rf_a_data),
      .rt_value (rf_b_data),
      .dec      (dec)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign csr_wr = csr_chan.valid && csr_chan.ready;

   assign pc_bad   = (pc_ff[1:0] != 2'b00) || (pc_ff >= DATA_W'(MEM_BYTES));
   assign data_bad = (dec.is_lw || dec.is_sw)
                   && ((dec.alu[1:0] != 2'b00) || (dec.alu >= DATA_W'(MEM_BYTES)));
   assign exec_fault = !dec.ok || data_bad;
   assign lw_go      = (state_ff == ST_EXEC) && dec.ok && dec.is_lw && !data_bad;
   assign widx_ok    = DATA_W'(req_ff.word_index) < DATA_W'(MEM_WORDS);
   assign slot_free  = !rsp_vld_ff || rsp_chan.ready;
   assign finish     = fin_state && slot_free;

   assign entry_state = !accept ? ST_IDLE
                      : (req_chan.req_type == REQ_EXEC) ? ST_FETCH : ST_SIMPLE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = entry_state;
         ST_FETCH: begin
            if (!(halt_ff || pc_bad)) begin
               state_in = ST_EXEC;
            end else if (finish) begin
               state_in = entry_state;
            end
         end
         ST_EXEC: begin
            if (lw_go) begin
               state_in = ST_MEM;
            end else if (finish) begin
               state_in = entry_state;
            end
         end
         ST_SIMPLE, ST_MEM: begin
            if (finish) begin
               state_in = entry_state;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fin_state = 1'b0;
      rf_a_en   = accept;
      rf_b_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: fin_state = 1'b0;
         ST_FETCH: begin
            fin_state = halt_ff || pc_bad;
            rf_a_en   = 1'b1;
            rf_b_en   = 1'b1;
         end
         ST_EXEC:           fin_state = !lw_go;
         ST_SIMPLE, ST_MEM: fin_state = 1'b1;
         default:           fin_state = 1'b0;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE) || finish;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      pc4 = pc_ff + DATA_W'(4);
      npc = pc4;
      if (dec.is_j) begin
         npc = {pc4[31:28], instr_ff[25:0], 2'b00};
      end else if (dec.is_beq && (dec.alu == '0)) begin
         npc = pc4 + {dec.imm[29:0], 2'b00};
      end
   end

   always_comb begin
      pc_in = pc_ff;
      if (csr_wr) begin
         pc_in = {{(DATA_W-START_W){1'b0}}, csr_chan.start_address};
      end else if (finish && (state_ff == ST_EXEC) && !exec_fault) begin
         pc_in = npc;
      end else if (finish && (state_ff == ST_MEM)) begin
         pc_in = pc4;
      end
   end

   assign halt_in = halt_ff
                  || (finish && (state_ff == ST_FETCH) && pc_bad)
                  || (finish && (state_ff == ST_EXEC) && exec_fault);

   assign mem_rd_en   = accept || ((state_ff == ST_EXEC) && lw_go);
   assign mem_rd_addr = accept ? pc_in[AW+1:2] : dec.alu[AW+1:2];

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(req_ff.word_index);
      mem_wr_data = req_ff.load_word;
      if (finish && (state_ff == ST_SIMPLE) && (req_ff.req_type == REQ_LOAD)) begin
         mem_wr_en = widx_ok;
      end else if (finish && (state_ff == ST_EXEC) && dec.is_sw && !exec_fault) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = dec.alu[AW+1:2];
         mem_wr_data = rf_b_data;
      end
   end

   assign rf_a_addr = accept ? req_chan.register_select : mem_rd_data[25:21];

   always_comb begin
      rf_wr = '0;
      if (finish && (state_ff == ST_EXEC) && !exec_fault && !dec.is_lw
          && (dec.dest != '0)) begin
         rf_wr.en   = 1'b1;
         rf_wr.addr = dec.dest;
         rf_wr.data = dec.alu;
      end else if (finish && (state_ff == ST_MEM) && (dest_ff != '0)) begin
         rf_wr.en   = 1'b1;
         rf_wr.addr = dest_ff;
         rf_wr.data = mem_rd_data;
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.pc_value = pc_in;
      rsp_in.halted   = halt_in;
      case (state_ff)
         ST_SIMPLE: begin
            if (req_ff.req_type == REQ_READ) begin
               rsp_in.register_value = rf_a_data;
            end
         end
         ST_EXEC: begin
            rsp_in.executed_instruction = instr_ff;
            rsp_in.alu_result           = dec.alu;
         end
         ST_MEM: begin
            rsp_in.executed_instruction = instr_ff;
            rsp_in.alu_result           = alu_ff;
         end
         default: rsp_in.alu_result = '0;
      endcase
      if (rf_wr.en) begin
         rsp_in.written_register = rf_wr.addr;
         rsp_in.written_value    = rf_wr.data;
      end
   end

   assign rsp_vld_in = finish || (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pc_ff      <= {{(DATA_W-START_W){1'b0}}, START_RESET};
         halt_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pc_ff      <= pc_in;
         halt_ff    <= halt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.req_type        <= req_chan.req_type;
         req_ff.word_index      <= req_chan.word_index;
         req_ff.load_word       <= req_chan.load_word;
         req_ff.register_select <= req_chan.register_select;
      end
      if (state_ff == ST_FETCH) begin
         instr_ff <= mem_rd_data;
      end
      if ((state_ff == ST_EXEC) && lw_go) begin
         alu_ff  <= dec.alu;
         dest_ff <= dec.dest;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid                = rsp_vld_ff;
   assign rsp_chan.pc_value             = rsp_ff.pc_value;
   assign rsp_chan.executed_instruction = rsp_ff.executed_instruction;
   assign rsp_chan.alu_result           = rsp_ff.alu_result;
   assign rsp_chan.halted               = rsp_ff.halted;
   assign rsp_chan.written_register     = rsp_ff.written_register;
   assign rsp_chan.written_value        = rsp_ff.written_value;
   assign rsp_chan.register_value       = rsp_ff.register_value;

   `MSSC_ASSERT(a_halt_sticky, clock, reset, halt_ff |=> halt_ff, "halt flag cleared")
   `MSSC_ASSERT(a_no_r0_write, clock, reset, rf_wr.en |-> (rf_wr.addr != '0), "r0 written")
   `MSSC_ASSERT(a_rf_wr_step, clock, reset, rf_wr.en |-> (state_ff >= ST_EXEC), "stray rf write")
   `MSSC_NEVER(a_mem_port_clash, clock, reset, mem_wr_en && lw_go, "store and load in one cycle")
   `MSSC_ASSERT(a_rsp_loaded, clock, reset, finish |=> rsp_vld_ff, "finished request lost")
endmodule
